// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define CBM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define CBM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

// ===== hdl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, register codes and the CPU write decoder of the cart bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE      = 2'd0,
    KIND_TICK       = 2'd1,
    KIND_CPU_LOOKUP = 2'd2,
    KIND_PPU_LOOKUP = 2'd3
  } kind_t;

  // CPU write decode: address is masked, then the two low bits are split off
  localparam logic [15:0] DECODE_MASK   = 16'h8073;
  localparam logic [15:0] REG_PRG       = 16'h8000;
  localparam logic [15:0] REG_CHR_LO    = 16'h8010;
  localparam logic [15:0] REG_CHR_HI    = 16'h8020;
  localparam logic [15:0] REG_IRQ_START = 16'h8030;
  localparam logic [15:0] REG_IRQ_STOP  = 16'h8040;
  localparam logic [15:0] REG_PAGE      = 16'h8050;

  localparam logic [7:0] FIXED_TOP_BANK = 8'hFF;
  localparam logic [1:0] TOP_PRG_SLOT   = 2'd3;
  localparam logic [5:0] PALETTE_PAGE   = 6'h3F;

  // Counter bit that fires the interrupt in each board variant
  localparam int FIRE_BIT_V0 = 10;
  localparam int FIRE_BIT_V1 = 12;

  // Configuration register word index
  localparam logic REG_IDX_BOARD_VARIANT = 1'b0;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  cycle_count;
  } item_t;

  typedef struct packed {
    logic       prg_we;
    logic       chr_we;
    logic [2:0] chr_idx;
    logic       page_we;
    logic       page_val;
    logic [1:0] low_idx;
    logic [7:0] data;
    logic       irq_start;
    logic       irq_stop;
  } wr_ctl_t;

  function automatic wr_ctl_t decode_write(input logic [15:0] address,
                                           input logic [7:0]  data,
                                           input logic        variant);
    wr_ctl_t     w;
    logic [15:0] sel;
    logic [15:0] sel_hi;
    logic [1:0]  low;
    w      = '0;
    sel    = address & DECODE_MASK;
    sel_hi = sel & 16'hFFFC;
    low    = address[1:0];
    w.low_idx = low;
    w.data    = data;
    unique case (sel_hi)
      REG_PRG: begin
        w.prg_we = 1'b1;
      end
      REG_CHR_LO: begin
        w.chr_we   = 1'b1;
        w.chr_idx  = {1'b0, low};
        w.page_we  = variant;
        w.page_val = data[7];
      end
      REG_CHR_HI: begin
        w.chr_we  = 1'b1;
        w.chr_idx = {1'b1, low};
      end
      REG_PAGE: begin
        w.page_we  = ~variant;
        w.page_val = data[0];
      end
      REG_IRQ_START: begin
        w.irq_start = (sel == REG_IRQ_START);
      end
      REG_IRQ_STOP: begin
        w.irq_stop = (sel == REG_IRQ_STOP);
      end
      default: begin
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/cart_bank_mapper_with_cycle_irq_top.sv =====
// ----------------------------------------------------------------------------
// cart_bank_mapper_with_cycle_irq_top
// Cartridge bank mapper with CPU cycle interrupt counter.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid / in_stall | kind, address, write_data, cycle_count
//  out      | out_valid/out_stall | irq_line, bank_number, nametable_page
//  config   | APB psel/penable    | paddr, pwdata, prdata (board_variant)
//
//  An accepted request sits in the input register during decode and lookup,
//  then loads the result register once that is free, and is offered there.
//  A new request is taken every cycle while in_stall is low; throughput is one
//  per cycle unless the result side stalls. A stalled full result register
//  raises in_stall in the same cycle when the input register holds a request.
//  Synchronous reset clears all bank, page and counter state; no clear pass.
// ----------------------------------------------------------------------------
module cart_bank_mapper_with_cycle_irq_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycle_count,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        irq_line,
  output logic [7:0]  bank_number,
  output logic        nametable_page,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic board_variant;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[2] == cbm_pkg::REG_IDX_BOARD_VARIANT);

  always_ff @(posedge clk) begin
    if (rst) begin
      board_variant <= 1'b0;
    end else if (cfg_write) begin
      board_variant <= pwdata[0];
    end
  end

  // Byte offset bits are ignored: read back by word index
  assign prdata = (paddr[2] == cbm_pkg::REG_IDX_BOARD_VARIANT) ?
                  {31'd0, board_variant} : 32'd0;

  // --------------------------------------------------------------------------
  // Flow control: input register feeding the result register
  // --------------------------------------------------------------------------
  logic           s1_valid;
  cbm_pkg::item_t s1_item;
  logic           out_free;
  logic           advance;
  logic           accept;

  // Result register can load when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture request payload; hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.kind        <= cbm_pkg::kind_t'(kind);
      s1_item.address     <= address;
      s1_item.write_data  <= write_data;
      s1_item.cycle_count <= cycle_count;
    end
  end

  // --------------------------------------------------------------------------
  // Decode and state update, committed only as the request advances
  // --------------------------------------------------------------------------
  cbm_pkg::wr_ctl_t wr_ctl;
  logic             tick_en;
  logic             irq_line_next;
  logic [7:0]       bank_lookup;
  logic             page_lookup;

  assign wr_ctl  = (advance && s1_item.kind == cbm_pkg::KIND_WRITE) ?
                   cbm_pkg::decode_write(s1_item.address, s1_item.write_data,
                                         board_variant) : '0;
  assign tick_en = advance && (s1_item.kind == cbm_pkg::KIND_TICK);

  cbm_bank_regs u_bank_regs (
    .clk            (clk),
    .rst            (rst),
    .ctl            (wr_ctl),
    .kind           (s1_item.kind),
    .address        (s1_item.address),
    .bank_number    (bank_lookup),
    .nametable_page (page_lookup)
  );

  cbm_irq_counter u_irq_counter (
    .clk           (clk),
    .rst           (rst),
    .ctl           (wr_ctl),
    .tick_en       (tick_en),
    .cycle_count   (s1_item.cycle_count),
    .board_variant (board_variant),
    .irq_line_next (irq_line_next)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load on advance; otherwise hold the shown result
  always_ff @(posedge clk) begin
    if (advance) begin
      irq_line       <= irq_line_next;
      bank_number    <= bank_lookup;
      nametable_page <= page_lookup;
    end
  end

endmodule

// ===== hdl/cbm_bank_regs.sv =====
// ----------------------------------------------------------------------------
// cbm_bank_regs
// PRG, CHR and nametable page registers with the CPU/PPU bank lookup.
// ----------------------------------------------------------------------------
module cbm_bank_regs (
  input  logic            clk,
  input  logic            rst,
  input  cbm_pkg::wr_ctl_t ctl,
  input  cbm_pkg::kind_t  kind,
  input  logic [15:0]     address,
  output logic [7:0]      bank_number,
  output logic            nametable_page
);

  logic [7:0] prg_bank_regs [4];
  logic [7:0] chr_bank_regs [8];
  logic [3:0] page_select_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) prg_bank_regs[i] <= '0;
      for (int i = 0; i < 8; i++) chr_bank_regs[i] <= '0;
      page_select_bits <= '0;
    end else begin
      if (ctl.prg_we) prg_bank_regs[ctl.low_idx] <= ctl.data;
      if (ctl.chr_we) chr_bank_regs[ctl.chr_idx] <= ctl.data;
      if (ctl.page_we) page_select_bits[ctl.low_idx] <= ctl.page_val;
    end
  end

  // PPU address space is 14 bits; upper bits mirror
  logic [13:0] ppu_addr;
  assign ppu_addr = address[13:0];

  always_comb begin
    bank_number    = '0;
    nametable_page = 1'b0;
    unique case (kind)
      cbm_pkg::KIND_CPU_LOOKUP: begin
        if (address[15]) begin
          bank_number = (address[14:13] == cbm_pkg::TOP_PRG_SLOT) ?
                        cbm_pkg::FIXED_TOP_BANK : prg_bank_regs[address[14:13]];
        end
      end
      cbm_pkg::KIND_PPU_LOOKUP: begin
        if (!ppu_addr[13]) begin
          bank_number = chr_bank_regs[ppu_addr[12:10]];
        end else if (ppu_addr[13:8] != cbm_pkg::PALETTE_PAGE) begin
          nametable_page = page_select_bits[ppu_addr[11:10]];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/cbm_irq_counter.sv =====
// ----------------------------------------------------------------------------
// cbm_irq_counter
// 16-bit CPU cycle counter with enable and latched interrupt line.
// ----------------------------------------------------------------------------
module cbm_irq_counter (
  input  logic             clk,
  input  logic             rst,
  input  cbm_pkg::wr_ctl_t ctl,
  input  logic             tick_en,
  input  logic [7:0]       cycle_count,
  input  logic             board_variant,
  output logic             irq_line_next
);

  logic [15:0] cycle_counter;
  logic [15:0] cycle_counter_next;
  logic        irq_enabled;
  logic        irq_enabled_next;
  logic        irq_pending;
  logic        irq_pending_next;
  logic [15:0] sum;
  logic        fire;

  assign sum  = cycle_counter + {8'd0, cycle_count};
  assign fire = irq_enabled &&
                (board_variant ? sum[cbm_pkg::FIRE_BIT_V1] : sum[cbm_pkg::FIRE_BIT_V0]);

  always_comb begin
    cycle_counter_next = cycle_counter;
    irq_enabled_next   = irq_enabled;
    irq_pending_next   = irq_pending;
    if (ctl.irq_start) begin
      cycle_counter_next = '0;
      irq_enabled_next   = 1'b1;
    end
    if (ctl.irq_stop) begin
      irq_enabled_next = 1'b0;
      irq_pending_next = 1'b0;
    end
    if (tick_en) begin
      cycle_counter_next = fire ? 16'd0 : sum;
      if (fire) irq_pending_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_counter <= '0;
      irq_enabled   <= 1'b0;
      irq_pending   <= 1'b0;
    end else begin
      cycle_counter <= cycle_counter_next;
      irq_enabled   <= irq_enabled_next;
      irq_pending   <= irq_pending_next;
    end
  end

  assign irq_line_next = irq_pending_next;

endmodule

// ===== hdl/cbm_checker.sv =====
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the cart bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       irq_line,
  input logic [7:0] bank_number,
  input logic       nametable_page
);

  // Reset empties the result register
  `CBM_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // A result never carries both a bank and a nametable page
  `CBM_ASSERT_IMPL(a_bank_xor_page, clk, rst, out_valid, (bank_number == 8'd0) || !nametable_page)

  // Input side only backs up when a result is waiting and stalled
  `CBM_ASSERT_IMPL(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // A stalled result stays offered
  `CBM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // A stalled result keeps its fields
  `CBM_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable({irq_line, bank_number, nametable_page}))

endmodule

bind cart_bank_mapper_with_cycle_irq_top cbm_checker u_cbm_checker (.*);
